// ===== rtl/hbm_pkg.sv =====
// Heartbeat monitor package: field widths, time modulus, reset values and
// the wrapped elapsed-time helper. No dependencies.
`timescale 1ns / 1ps

package hbm_pkg;

    localparam int TIME_W   = 8;
    localparam int IDX_W    = 3;
    localparam int TIME_MOD = 240;

    localparam logic [TIME_W-1:0] TIMEOUT_RST = 8'd2;
    localparam logic [TIME_W-1:0] TIME_LAST   = 8'(TIME_MOD - 1);

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_HBEAT = 1'b1;

    // (now - stamp) mod 240, both operands below 240
    function automatic logic [TIME_W-1:0] elapsed(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] stamp
    );
        logic [TIME_W:0] diff;
        diff = {1'b0, now} - {1'b0, stamp};
        if (diff[TIME_W]) begin
            diff = diff + (TIME_W + 1)'(TIME_MOD);
        end
        return diff[TIME_W-1:0];
    endfunction

endpackage

// ===== rtl/hbm_req_if.sv =====
// Request channel: tick or heartbeat beat with valid/ready.
// Depends on hbm_pkg.
`timescale 1ns / 1ps

interface hbm_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [hbm_pkg::IDX_W-1:0]  device_index;

    modport source (output valid, req_type, device_index, input ready);
    modport sink   (input valid, req_type, device_index, output ready);
endinterface

// ===== rtl/hbm_res_if.sv =====
// Result channel: failure report beat with valid/ready.
// Depends on hbm_pkg.
`timescale 1ns / 1ps

interface hbm_res_if;
    logic                        valid;
    logic                        ready;
    logic                        fail_found;
    logic [hbm_pkg::IDX_W-1:0]   fail_index;
    logic [hbm_pkg::TIME_W-1:0]  current_time;

    modport source (output valid, fail_found, fail_index, current_time, input ready);
    modport sink   (input valid, fail_found, fail_index, current_time, output ready);
endinterface

// ===== rtl/device_heartbeat_timeout_monitor.sv =====
// Heartbeat timeout monitor top level. Depends on hbm_pkg, hbm_req_if,
// hbm_res_if and hbm_stamp_ram.
// Each accepted beat starts a scan that reads one stamp a cycle and stops early at
// the first loss. A new beat is taken only once the previous scan's result has moved
// to the output register, so beats are handled one at a time.
// Synchronous active-low reset: time 0, timeout 2, all stamps read as 0.
`timescale 1ns / 1ps

module device_heartbeat_timeout_monitor #(
    parameter int NUM_DEVICES = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    hbm_req_if.sink                     i_req,
    hbm_res_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  logic [hbm_pkg::TIME_W-1:0]  i_cfg_wdata
);

    localparam int ADDR_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam int CNT_W  = $clog2(NUM_DEVICES + 1);
    localparam logic [ADDR_W-1:0] LAST_DEV = ADDR_W'(NUM_DEVICES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_HOLD = 3'b100
    } t_state;

    t_state                      r_state, n_state;
    logic [hbm_pkg::TIME_W-1:0]  r_timeout;
    logic [hbm_pkg::TIME_W-1:0]  r_now;
    logic [CNT_W-1:0]            r_issue;
    logic                        r_chk_v;
    logic [ADDR_W-1:0]           r_chk_idx;
    logic                        r_res_found;
    logic [hbm_pkg::IDX_W-1:0]   r_res_idx;
    logic                        r_out_valid;
    logic                        r_out_found;
    logic [hbm_pkg::IDX_W-1:0]   r_out_idx;
    logic [hbm_pkg::TIME_W-1:0]  r_out_time;

    logic                        in_beat;
    logic                        hb_we;
    logic                        rd_en;
    logic [hbm_pkg::TIME_W-1:0]  rd_stamp;
    logic                        over;
    logic                        scan_done;
    logic                        out_free;

    assign in_beat  = i_req.valid && i_req.ready;
    assign hb_we    = in_beat && (i_req.req_type == hbm_pkg::REQ_HBEAT)
                      && (32'(i_req.device_index) < NUM_DEVICES);
    assign rd_en    = (r_state == S_SCAN) && (32'(r_issue) < NUM_DEVICES);
    assign over     = hbm_pkg::elapsed(r_now, rd_stamp) > r_timeout;
    assign scan_done = (r_state == S_SCAN) && r_chk_v && (over || r_chk_idx == LAST_DEV);
    assign out_free = !r_out_valid || o_res.ready;

    hbm_stamp_ram #(
        .DEPTH  (NUM_DEVICES),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (hb_we),
        .i_waddr (ADDR_W'(i_req.device_index)),
        .i_wdata (r_now),
        .i_re    (rd_en),
        .i_raddr (r_issue[ADDR_W-1:0]),
        .o_rdata (rd_stamp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_done) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timeout   <= hbm_pkg::TIMEOUT_RST;
            r_now       <= '0;
            r_issue     <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (in_beat && i_req.req_type == hbm_pkg::REQ_TICK) begin
                r_now <= (r_now == hbm_pkg::TIME_LAST) ? '0 : r_now + 1'b1;
            end
            if (r_state == S_SCAN && !scan_done) begin
                r_chk_v <= rd_en;
                if (rd_en) r_issue <= r_issue + 1'b1;
            end else begin
                r_chk_v <= 1'b0;
                r_issue <= '0;
            end
            if (r_state == S_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_chk_idx <= r_issue[ADDR_W-1:0];
        end
        if (scan_done) begin
            r_res_found <= over;
            r_res_idx   <= over ? hbm_pkg::IDX_W'(r_chk_idx) : '0;
        end
        if (r_state == S_HOLD && out_free) begin
            r_out_found <= r_res_found;
            r_out_idx   <= r_res_idx;
            r_out_time  <= r_now;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.fail_found   = r_out_found;
    assign o_res.fail_index   = r_out_idx;
    assign o_res.current_time = r_out_time;

endmodule

// ===== rtl/hbm_stamp_ram.sv =====
// Last-seen stamp store: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Depends on hbm_pkg.
`timescale 1ns / 1ps

module hbm_stamp_ram #(
    parameter int DEPTH  = 5,
    parameter int ADDR_W = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic [ADDR_W-1:0]           i_waddr,
    input  logic [hbm_pkg::TIME_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [ADDR_W-1:0]           i_raddr,
    output logic [hbm_pkg::TIME_W-1:0]  o_rdata
);

    logic [hbm_pkg::TIME_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic [hbm_pkg::TIME_W-1:0] r_rdata;
    logic                       r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : '0;

endmodule

// ===== rtl/hbm_checker.sv =====
// Port-level checks on the heartbeat monitor, bound to the top level.
// Depends on hbm_pkg and device_heartbeat_timeout_monitor.
`timescale 1ns / 1ps

module hbm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic                        i_fail_found,
    input logic [hbm_pkg::IDX_W-1:0]   i_fail_index,
    input logic [hbm_pkg::TIME_W-1:0]  i_current_time
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat shown straight after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken before scan");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_current_time <= hbm_pkg::TIME_LAST)
        else $error("time out of range");

    a_none_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_fail_found |-> i_fail_index == '0)
        else $error("index set with no failure");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fail_found)
        && $stable(i_fail_index) && $stable(i_current_time))
        else $error("stalled result beat changed");

endmodule

bind device_heartbeat_timeout_monitor hbm_checker u_hbm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_fail_found   (o_res.fail_found),
    .i_fail_index   (o_res.fail_index),
    .i_current_time (o_res.current_time)
);
